[rtl/hmrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmrp_pkg
// Shared types, constants and helpers of the height-grid placement checker.
// ----------------------------------------------------------------------------
package hmrp_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int HEIGHT_BITS = 9;

  localparam int FRAC      = 4;
  localparam int ROW_BITS  = $clog2(MAX_ROWS);
  localparam int COL_BITS  = $clog2(MAX_COLS);
  localparam int ROWN_BITS = $clog2(MAX_ROWS + 1);
  localparam int COLN_BITS = $clog2(MAX_COLS + 1);
  localparam int ADDR_BITS = ROW_BITS + COL_BITS;
  localparam int GRID_DEPTH = 1 << ADDR_BITS;

  // field and register widths
  localparam int POS_W     = 13;
  localparam int SIZE_W    = 11;
  localparam int HH_W      = 13;
  localparam int DIM_W     = 7;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 13;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int KIND_W     = 2;
  localparam int CORNER_W   = 3;

  localparam int COORD_W = 16;
  localparam int ZS_W    = 15;
  localparam int H_W     = 11;
  localparam int HCMP_W  = (HEIGHT_BITS > H_W) ? HEIGHT_BITS : H_W;

  typedef logic signed [COORD_W-1:0]     coord_t;
  typedef logic signed [H_W-1:0]         hq_t;
  typedef logic signed [HCMP_W-1:0]      hx_t;
  typedef logic signed [HEIGHT_BITS-1:0] cell_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [ROWN_BITS-1:0]          rown_t;
  typedef logic [COLN_BITS-1:0]          coln_t;
  typedef logic [SIZE_W-1:0]             size_t;

  localparam coord_t ONE_CELL   = coord_t'(1 << FRAC);
  localparam cell_t  FILL_FLOOR = cell_t'(2);
  localparam cell_t  CELL_RESET = '1;
  localparam hx_t    CELL_MAX   = hx_t'((1 << (HEIGHT_BITS - 1)) - 1);
  localparam hx_t    CELL_MIN   = -CELL_MAX - hx_t'(1);

  // request codes
  localparam logic [KIND_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] REQ_FILL  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_QUERY = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_LEN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HALF_WID    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HALF_HGT    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RECT_HLEN   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RECT_HWID   = 3'd6;

  typedef enum logic [2:0] {
    PRB_PP, PRB_PM, PRB_MP, PRB_MM, PRB_CTR
  } probe_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_QUERY, ST_FILL, ST_TAIL, ST_DONE
  } state_t;

  typedef struct packed {
    logic  on;
    addr_t addr;
  } loc_t;

  typedef struct packed {
    logic              vld;
    logic              on;
    logic [KIND_W-1:0] kind;
    logic              first_col;
    logic              ctr;
  } eval_t;

  function automatic hq_t round_height(input logic signed [POS_W-1:0] z,
                                       input logic [HH_W-1:0] hh);
    logic signed [ZS_W-1:0] s;
    logic [ZS_W-1:0]        mag;
    logic [ZS_W-1:0]        rr;
    hq_t                    hq;
    s   = ZS_W'(z) + $signed({2'b00, hh});
    mag = s[ZS_W-1] ? ZS_W'(-s) : ZS_W'(s);
    rr  = (mag + ZS_W'(8)) >> FRAC;
    hq  = hq_t'(rr);
    return s[ZS_W-1] ? -hq : hq;
  endfunction

  function automatic cell_t sat_height(input hq_t h);
    hx_t hx;
    hx = hx_t'(h);
    if (hx > CELL_MAX) hx = CELL_MAX;
    if (hx < CELL_MIN) hx = CELL_MIN;
    return cell_t'(hx[HEIGHT_BITS-1:0]);
  endfunction

endpackage

[rtl/hmrp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmrp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hmrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/hmrp_probe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmrp_probe
// Probe locator: offsets the shifted point to one rectangle corner or the
// centre and maps it to a grid cell, flagging points off the grid in use.
// ----------------------------------------------------------------------------
module hmrp_probe (
  input  hmrp_pkg::coord_t     xs,
  input  hmrp_pkg::coord_t     ys,
  input  hmrp_pkg::size_t      rl,
  input  hmrp_pkg::size_t      rw,
  input  hmrp_pkg::probe_idx_t sel,
  input  hmrp_pkg::rown_t      rows_n,
  input  hmrp_pkg::coln_t      cols_n,
  output hmrp_pkg::loc_t       loc
);
  import hmrp_pkg::*;

  coord_t dx, dy, px, py, row_lim, col_lim;
  logic   row_ok, col_ok;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col;

  always_comb begin
    case (sel)
      PRB_PP:  begin dx =  coord_t'(rl); dy =  coord_t'(rw); end
      PRB_PM:  begin dx =  coord_t'(rl); dy = -coord_t'(rw); end
      PRB_MP:  begin dx = -coord_t'(rl); dy =  coord_t'(rw); end
      PRB_MM:  begin dx = -coord_t'(rl); dy = -coord_t'(rw); end
      default: begin dx = '0;            dy = '0;            end
    endcase
    px      = xs + dx;
    py      = ys + dy;
    row_lim = coord_t'({rows_n, {FRAC{1'b0}}});
    col_lim = coord_t'({cols_n, {FRAC{1'b0}}});
    row_ok  = (rows_n != '0) && (px > -ONE_CELL) && (px < row_lim);
    col_ok  = (cols_n != '0) && (py > -ONE_CELL) && (py < col_lim);
    row     = px[COORD_W-1] ? '0 : px[FRAC +: ROW_BITS];
    col     = py[COORD_W-1] ? '0 : py[FRAC +: COL_BITS];
    loc.on   = row_ok && col_ok;
    loc.addr = {row, col};
  end

endmodule

[rtl/heightmap_rect_placement_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_rect_placement_check
// Height grid with point loading, row gap filling and rectangle placement
// queries, held in one on-chip RAM.
// ----------------------------------------------------------------------------
// Input words carry the request kind in in_tuser (0 load, 1 fill, 2 query)
// and the point in in_tdata. Each load, fill or query returns one output
// word: the kind echoed in out_tuser and the query verdict in out_tdata.
// Kind 3 words are taken and dropped without a result.
// One request is worked at a time; the grid sits in a 4096 x 9 RAM with
// one write and one registered read port.
//   load : one read-modify-write of the addressed cell
//   query: five cell reads, one per cycle, pipelined with the
//          compare of the previous read
//   fill : one cell per cycle, row by row, over the grid in use
// The next word is accepted in the cycle after the result is registered.
// After reset the block sweeps the RAM writing -1, one cell per cycle,
// with in_tready low; configuration writes are taken as usual.
// A result waits in the output register while out_tready is low; a
// finished request holds until that register frees.
// ----------------------------------------------------------------------------
module heightmap_rect_placement_check (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x [12:0], pos_y [25:13], pos_z [38:26], zero [39]
  input  logic [hmrp_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type [1:0]
  input  logic [hmrp_pkg::KIND_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // collides [0], corners_level [3:1], center_level [4], zero [7:5]
  output logic [hmrp_pkg::OUT_DATA_W-1:0]    out_tdata,
  // kind_done [1:0]
  output logic [hmrp_pkg::KIND_W-1:0]        out_tuser,
  input  logic                               cfg_we,
  input  logic [hmrp_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [hmrp_pkg::CFG_W-1:0]         cfg_wdata
);
  import hmrp_pkg::*;

  // configuration
  logic [DIM_W-1:0] grid_rows_r, grid_cols_r;
  size_t            half_length_r, half_width_r, rect_hlen_r, rect_hwid_r;
  logic [HH_W-1:0]  half_height_r;

  // control and datapath
  state_t            state_r, state_nxt;
  addr_t             clr_addr_r, clr_addr_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  coord_t            xs_r, xs_nxt, ys_r, ys_nxt;
  hq_t               h_r, h_nxt;
  probe_idx_t        prb_r, prb_nxt;
  logic [ROW_BITS-1:0] frow_r, frow_nxt;
  logic [COL_BITS-1:0] fcol_r, fcol_nxt;
  eval_t             ev_r, ev_nxt;
  addr_t             ev_addr_r, ev_addr_nxt;
  logic              collide_r, collide_nxt, center_r, center_nxt;
  logic [CORNER_W-1:0] corners_r, corners_nxt;
  cell_t             prev_r, prev_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;

  // combinational
  rown_t      rows_n;
  coln_t      cols_n;
  probe_idx_t prb_sel;
  loc_t       loc;
  logic       in_acc, out_free, grid_empty, col_last, row_last;
  logic       rd_en, issue, issue_on;
  addr_t      rd_addr;
  cell_t      rd_data;
  logic       wr_en;
  addr_t      wr_addr;
  cell_t      wr_data;
  cell_t      load_val, fill_val;
  hx_t        d_x, h_x;
  logic       fin_collide;

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r   <= DIM_W'(37);
      grid_cols_r   <= DIM_W'(47);
      half_length_r <= SIZE_W'(296);
      half_width_r  <= SIZE_W'(376);
      half_height_r <= HH_W'(212);
      rect_hlen_r   <= SIZE_W'(80);
      rect_hwid_r   <= SIZE_W'(48);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_ROWS: grid_rows_r   <= cfg_wdata[DIM_W-1:0];
        REG_GRID_COLS: grid_cols_r   <= cfg_wdata[DIM_W-1:0];
        REG_HALF_LEN:  half_length_r <= cfg_wdata[SIZE_W-1:0];
        REG_HALF_WID:  half_width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_HALF_HGT:  half_height_r <= cfg_wdata[HH_W-1:0];
        REG_RECT_HLEN: rect_hlen_r   <= cfg_wdata[SIZE_W-1:0];
        REG_RECT_HWID: rect_hwid_r   <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_n = (32'(grid_rows_r) > MAX_ROWS) ? rown_t'(MAX_ROWS) : rown_t'(grid_rows_r);
  assign cols_n = (32'(grid_cols_r) > MAX_COLS) ? coln_t'(MAX_COLS) : coln_t'(grid_cols_r);

  assign grid_empty = (rows_n == '0) || (cols_n == '0);
  assign col_last   = (coln_t'(fcol_r) + coln_t'(1)) == cols_n;
  assign row_last   = (rown_t'(frow_r) + rown_t'(1)) == rows_n;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  // ---- probe address
  hmrp_probe u_probe (
    .xs     (xs_r),
    .ys     (ys_r),
    .rl     (rect_hlen_r),
    .rw     (rect_hwid_r),
    .sel    (prb_sel),
    .rows_n (rows_n),
    .cols_n (cols_n),
    .loc    (loc)
  );

  // ---- grid memory
  hmrp_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_LOAD:  state_nxt = ST_LOAD;
            REQ_FILL:  state_nxt = ST_FILL;
            REQ_QUERY: state_nxt = ST_QUERY;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_nxt = ST_TAIL;
      ST_QUERY: if (prb_r == PRB_CTR) state_nxt = ST_TAIL;
      ST_FILL: begin
        if (grid_empty) state_nxt = ST_DONE;
        else if (col_last && row_last) state_nxt = ST_TAIL;
      end
      ST_TAIL:  state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- state outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    issue     = 1'b0;
    issue_on  = 1'b0;
    prb_sel   = PRB_CTR;
    rd_addr   = loc.addr;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_LOAD: begin
        rd_en    = 1'b1;
        issue    = 1'b1;
        issue_on = loc.on;
      end
      ST_QUERY: begin
        prb_sel  = prb_r;
        rd_en    = 1'b1;
        issue    = 1'b1;
        issue_on = loc.on;
      end
      ST_FILL: begin
        rd_addr  = {frow_r, fcol_r};
        rd_en    = !grid_empty;
        issue    = !grid_empty;
        issue_on = 1'b1;
      end
      default: ;
    endcase
  end

  // ---- evaluate the word read last cycle
  assign d_x      = hx_t'(rd_data);
  assign h_x      = hx_t'(h_r);
  assign load_val = sat_height(h_r);
  assign fill_val = (rd_data < FILL_FLOOR) ? (ev_r.first_col ? FILL_FLOOR : prev_r)
                                           : rd_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ev_addr_r;
    wr_data = fill_val;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = CELL_RESET;
    end else if (ev_r.vld && ev_r.on) begin
      case (ev_r.kind)
        REQ_LOAD: begin
          wr_en   = load_val > rd_data;
          wr_data = load_val;
        end
        REQ_FILL: wr_en = 1'b1;
        default:  wr_en = 1'b0;
      endcase
    end
  end

  assign fin_collide = (kind_r == REQ_QUERY) &&
                       (collide_r || (center_r ? (corners_r == '0)
                                               : (corners_r < CORNER_W'(3))));

  // ---- datapath next values
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    kind_nxt      = kind_r;
    xs_nxt        = xs_r;
    ys_nxt        = ys_r;
    h_nxt         = h_r;
    prb_nxt       = prb_r;
    frow_nxt      = frow_r;
    fcol_nxt      = fcol_r;
    collide_nxt   = collide_r;
    center_nxt    = center_r;
    corners_nxt   = corners_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;

    ev_nxt.vld       = issue;
    ev_nxt.on        = issue_on;
    ev_nxt.kind      = kind_r;
    ev_nxt.first_col = (fcol_r == '0);
    ev_nxt.ctr       = (prb_r == PRB_CTR);
    ev_addr_nxt      = rd_addr;

    if (state_r == ST_CLEAR) clr_addr_nxt = clr_addr_r + addr_t'(1);

    if (in_acc) begin
      kind_nxt    = in_tuser;
      xs_nxt      = coord_t'($signed(in_tdata[POS_W-1:0])) + coord_t'(half_length_r);
      ys_nxt      = coord_t'($signed(in_tdata[2*POS_W-1:POS_W])) + coord_t'(half_width_r);
      h_nxt       = round_height($signed(in_tdata[3*POS_W-1:2*POS_W]), half_height_r);
      prb_nxt     = PRB_PP;
      frow_nxt    = '0;
      fcol_nxt    = '0;
      collide_nxt = 1'b0;
      center_nxt  = 1'b0;
      corners_nxt = '0;
    end

    if (state_r == ST_QUERY && prb_r != PRB_CTR) prb_nxt = probe_idx_t'(prb_r + 3'd1);

    if (state_r == ST_FILL && !grid_empty) begin
      if (col_last) begin
        fcol_nxt = '0;
        frow_nxt = frow_r + ROW_BITS'(1);
      end else begin
        fcol_nxt = fcol_r + COL_BITS'(1);
      end
    end

    if (ev_r.vld) begin
      case (ev_r.kind)
        REQ_QUERY: begin
          if (!ev_r.on || d_x > h_x) begin
            collide_nxt = 1'b1;
          end else if (d_x == h_x) begin
            if (ev_r.ctr) center_nxt = 1'b1;
            else corners_nxt = corners_r + CORNER_W'(1);
          end
        end
        REQ_FILL: prev_nxt = fill_val;
        default: ;
      endcase
    end

    if (out_tready) out_valid_nxt = 1'b0;
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = kind_r;
      out_data_nxt  = {3'b000, center_r, corners_r, fin_collide};
      if (kind_r != REQ_QUERY) out_data_nxt = '0;
    end
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ev_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    xs_r       <= xs_nxt;
    ys_r       <= ys_nxt;
    h_r        <= h_nxt;
    prb_r      <= prb_nxt;
    frow_r     <= frow_nxt;
    fcol_r     <= fcol_nxt;
    ev_addr_r  <= ev_addr_nxt;
    collide_r  <= collide_nxt;
    center_r   <= center_nxt;
    corners_r  <= corners_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

[bench/tb_heightmap_rect_placement_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_rect_placement_check
// Self-checking bench for the height-grid rectangle placement checker. A
// driver streams load, fill and query words from a pending queue; a shadow
// grid predicts each verdict at acceptance and a monitor checks every output
// word against the oldest prediction. Grid sizes, box offsets and rectangle
// sizes change between phases while the block is idle. Random gaps stall both
// sides; one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_heightmap_rect_placement_check;
  import hmrp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam longint LIMIT_NS = 64'd2_000_000 * 12;
  localparam int SETTLE       = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int FILL_MIN     = 2;
  localparam int CELL_HI      = (1 << (HEIGHT_BITS - 1)) - 1;
  localparam int CELL_LO      = -CELL_HI - 1;
  localparam logic [KIND_W-1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic signed [12:0]  x;
    logic signed [12:0]  y;
    logic signed [12:0]  z;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                collides;
    logic [CORNER_W-1:0] corners;
    logic                center;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  req_t        pending_reqs [$];
  verdict_t    verdicts_due [$];
  req_t        cur_req;
  verdict_t    want;
  int          hgrid [GRID_DEPTH];
  int unsigned cfg_shadow [7];
  int          errors = 0;
  int          queued_items = 0;
  int          lvl = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  logic        hold_go = 1'b0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  heightmap_rect_placement_check i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL heightmap_rect_placement_check");
    $finish;
  end

  // --------------------------------------------------------------------------
  // shadow grid
  // --------------------------------------------------------------------------
  function automatic int reg_width(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_GRID_ROWS, REG_GRID_COLS: return 7;
      REG_HALF_HGT:                 return 13;
      default:                      return 11;
    endcase
  endfunction

  function automatic int rows_in_use();
    return (cfg_shadow[REG_GRID_ROWS] > MAX_ROWS) ? MAX_ROWS : int'(cfg_shadow[REG_GRID_ROWS]);
  endfunction

  function automatic int cols_in_use();
    return (cfg_shadow[REG_GRID_COLS] > MAX_COLS) ? MAX_COLS : int'(cfg_shadow[REG_GRID_COLS]);
  endfunction

  function automatic int trunc16(int v);
    return (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
  endfunction

  function automatic int round16(int v);
    return (v >= 0) ? ((v + 8) >>> FRAC) : -(((-v) + 8) >>> FRAC);
  endfunction

  function automatic int probe_dx(int k, int half);
    if (k == PRB_CTR) return 0;
    return (k == PRB_PP || k == PRB_PM) ? half : -half;
  endfunction

  function automatic int probe_dy(int k, int half);
    if (k == PRB_CTR) return 0;
    return (k == PRB_PP || k == PRB_MP) ? half : -half;
  endfunction

  function automatic bit cell_of(int x, int y, output int idx);
    int r;
    int c;
    r = trunc16(x + int'(cfg_shadow[REG_HALF_LEN]));
    c = trunc16(y + int'(cfg_shadow[REG_HALF_WID]));
    idx = 0;
    if (r < 0 || r >= rows_in_use() || c < 0 || c >= cols_in_use()) return 1'b0;
    idx = r * MAX_COLS + c;
    return 1'b1;
  endfunction

  function automatic verdict_t place_verdict(req_t r);
    verdict_t v;
    int x, y, h, s, idx, k, nr, nc, rr, cc, base, corners;
    bit blocked;
    bit ctr;
    v = '0;
    v.kind = r.kind;
    x = $signed(r.x);
    y = $signed(r.y);
    h = round16($signed(r.z) + int'(cfg_shadow[REG_HALF_HGT]));
    corners = 0;
    blocked = 1'b0;
    ctr = 1'b0;
    case (r.kind)
      REQ_LOAD: begin
        if (cell_of(x, y, idx)) begin
          s = (h > CELL_HI) ? CELL_HI : ((h < CELL_LO) ? CELL_LO : h);
          if (s > hgrid[idx]) hgrid[idx] = s;
        end
      end
      REQ_FILL: begin
        nr = rows_in_use();
        nc = cols_in_use();
        for (rr = 0; rr < nr; rr++) begin
          base = rr * MAX_COLS;
          if (nc > 0 && hgrid[base] < FILL_MIN) hgrid[base] = FILL_MIN;
          for (cc = 1; cc < nc; cc++)
            if (hgrid[base + cc] < FILL_MIN) hgrid[base + cc] = hgrid[base + cc - 1];
        end
      end
      default: begin
        for (k = 0; k < 5; k++) begin
          if (!cell_of(x + probe_dx(k, int'(cfg_shadow[REG_RECT_HLEN])),
                       y + probe_dy(k, int'(cfg_shadow[REG_RECT_HWID])), idx)) begin
            blocked = 1'b1;
          end else if (hgrid[idx] > h) begin
            blocked = 1'b1;
          end else if (hgrid[idx] == h) begin
            if (k == PRB_CTR) ctr = 1'b1;
            else corners++;
          end
        end
        if (ctr ? (corners < 1) : (corners < 3)) blocked = 1'b1;
        v.collides = blocked;
        v.corners  = CORNER_W'(corners);
        v.center   = ctr;
      end
    endcase
    return v;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready && cur_req.kind != REQ_NONE)
        verdicts_due = {verdicts_due, place_verdict(cur_req)};
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          in_tvalid <= 1'b0;
          tx_gap    <= tx_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          cur_req   = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, cur_req.z, cur_req.y, cur_req.x};
          in_tuser  <= cur_req.kind;
          tx_gap    <= pick_gap(tx_steady);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output hold-off and monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: word with nothing expected, got kind %0d data %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: kind_done expected %0d got %0d", $time, want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[0] !== want.collides) begin
          $display("%0t: collides expected %0d got %0d", $time, want.collides, out_tdata[0]);
          errors++;
        end
        if (out_tdata[3:1] !== want.corners) begin
          $display("%0t: corners_level expected %0d got %0d",
                   $time, want.corners, out_tdata[3:1]);
          errors++;
        end
        if (out_tdata[4] !== want.center) begin
          $display("%0t: center_level expected %0d got %0d", $time, want.center, out_tdata[4]);
          errors++;
        end
      end
    end
    if (!rst_n || hold_left != 0) begin
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_tready <= 1'b0;
      rx_gap     <= rx_gap - 1;
    end else begin
      out_tready <= 1'b1;
      rx_gap     <= pick_gap(rx_steady);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic int clip13(int v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  function automatic int rand13();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic int near_coord(int half, int n);
    if (n == 0) return clip13(int'($urandom_range(0, 63)) - half);
    return clip13(int'($urandom_range(0, n * 16 - 1)) - half);
  endfunction

  function automatic int edge_coord(int half, int n);
    case ($urandom_range(0, 3))
      0:       return clip13(-half - int'($urandom_range(1, 15)));
      1:       return clip13(-half - 16 - int'($urandom_range(0, 15)));
      2:       return clip13(n * 16 - half + int'($urandom_range(0, 15)));
      default: return clip13(n * 16 - half - 1);
    endcase
  endfunction

  function automatic int z_at(int hgt);
    return clip13(hgt * 16 - int'(cfg_shadow[REG_HALF_HGT]) + int'($urandom_range(0, 15)) - 8);
  endfunction

  task automatic push_req(logic [KIND_W-1:0] kind, int x, int y, int z);
    req_t r;
    r.kind = kind;
    r.x = 13'(clip13(x));
    r.y = 13'(clip13(y));
    r.z = 13'(clip13(z));
    pending_reqs = {pending_reqs, r};
    if (kind != REQ_NONE) queued_items++;
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
    int unsigned masked;
    masked = val & ((32'd1 << reg_width(idx)) - 1);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_W'(masked);
    cfg_shadow[idx] = masked;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || verdicts_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // loads some of a rectangle's probe cells at one level, at times one cell a level higher, then queries there
  task automatic plateau_seq();
    int x, y, k, bump, hl, hw, rl, rw;
    logic [4:0] mask;
    hl = int'(cfg_shadow[REG_HALF_LEN]);
    hw = int'(cfg_shadow[REG_HALF_WID]);
    rl = int'(cfg_shadow[REG_RECT_HLEN]);
    rw = int'(cfg_shadow[REG_RECT_HWID]);
    x = near_coord(hl, rows_in_use());
    y = near_coord(hw, cols_in_use());
    if ($urandom_range(0, 9) < 7) lvl += $urandom_range(1, 3);
    else lvl = int'($urandom_range(0, 1100)) - 300;
    mask = ($urandom_range(0, 2) == 0) ? 5'h1f : 5'($urandom_range(0, 31));
    bump = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 7;
    for (k = 0; k < 5; k++)
      if (mask[k])
        push_req(REQ_LOAD, x + probe_dx(k, rl), y + probe_dy(k, rw),
                 z_at((k == bump) ? lvl + 1 : lvl));
    case ($urandom_range(0, 9))
      0:       push_req(REQ_QUERY, x, y, z_at(lvl + 1));
      1:       push_req(REQ_QUERY, x, y, z_at(lvl - 1));
      default: push_req(REQ_QUERY, x, y, z_at(lvl));
    endcase
  endtask

  task automatic run_phase(int rows, int cols, int hl, int hw, int hh, int rl, int rw,
                           int n_items, bit hold);
    int target, sel, fills_left, nr, nc;
    wait_idle();
    tx_steady = ($urandom_range(0, 4) == 0);
    rx_steady = ($urandom_range(0, 4) == 0);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLS, cols);
    write_reg(REG_HALF_LEN, hl);
    write_reg(REG_HALF_WID, hw);
    write_reg(REG_HALF_HGT, hh);
    write_reg(REG_RECT_HLEN, rl);
    write_reg(REG_RECT_HWID, rw);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (hold) begin
      @(posedge clk);
      hold_go <= 1'b1;
      @(posedge clk);
      hold_go <= 1'b0;
    end
    @(negedge clk);
    nr = rows_in_use();
    nc = cols_in_use();
    fills_left = (nr * nc > 1024) ? 3 : 1000;
    lvl = int'($urandom_range(0, 40)) - 10;
    target = queued_items + n_items;
    while (queued_items < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        plateau_seq();
      end else if (sel < 60) begin
        push_req(REQ_LOAD, near_coord(hl, nr), near_coord(hw, nc), rand13());
      end else if (sel < 70) begin
        push_req(REQ_QUERY, near_coord(hl, nr), near_coord(hw, nc),
                 z_at($urandom_range(0, 12)));
      end else if (sel < 77) begin
        push_req(KIND_W'($urandom_range(0, 3)), rand13(), rand13(), rand13());
      end else if (sel < 84) begin
        push_req(sel[0] ? REQ_LOAD : REQ_QUERY, edge_coord(hl, nr),
                 sel[1] ? edge_coord(hw, nc) : near_coord(hw, nc), z_at(lvl));
      end else if (sel < 90 && fills_left > 0) begin
        fills_left--;
        push_req(REQ_FILL, rand13(), rand13(), rand13());
        if ($urandom_range(0, 1) != 0)
          push_req(REQ_QUERY, near_coord(hl, nr), near_coord(hw, nc), z_at(FILL_MIN));
      end else begin
        push_req(REQ_QUERY, near_coord(hl, nr), near_coord(hw, nc), z_at(FILL_MIN));
      end
    end
  endtask

  initial begin
    int k;
    cfg_shadow = '{37, 47, 296, 376, 212, 80, 48};
    for (k = 0; k < GRID_DEPTH; k++) hgrid[k] = -1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words at the reset register values
    push_req(REQ_QUERY, 0, 0, -228);
    push_req(REQ_LOAD, -4096, -4096, -4096);
    push_req(REQ_LOAD, 4095, 4095, 4095);
    push_req(REQ_QUERY, 4095, 4095, 4095);
    push_req(REQ_LOAD, -311, -377, 4095);
    push_req(REQ_QUERY, -311, -377, 4095);
    push_req(REQ_LOAD, 280, 360, -204);
    push_req(REQ_LOAD, 296, 0, 0);
    push_req(REQ_LOAD, 0, 0, -220);
    for (k = 0; k < 5; k++)
      push_req(REQ_LOAD, probe_dx(k, 80), probe_dy(k, 48), -132);
    push_req(REQ_QUERY, 0, 0, -132);
    push_req(REQ_QUERY, 0, 0, -148);
    push_req(REQ_LOAD, 80, 48, -116);
    push_req(REQ_QUERY, 0, 0, -116);
    push_req(REQ_QUERY, 0, 0, -132);
    push_req(REQ_NONE, 1, 2, 3);
    push_req(REQ_FILL, 0, 0, 0);
    push_req(REQ_QUERY, -200, -300, -180);
    push_req(REQ_QUERY, -4096, -1, -1);
    push_req(REQ_LOAD, -1, 4095, 4095);

    run_phase(8, 8, 64, 64, 100, 16, 16, 130, 1'b1);
    run_phase(1, 1, 0, 0, 0, 0, 0, 60, 1'b0);
    run_phase(0, 20, 128, 128, 64, 16, 16, 30, 1'b0);
    run_phase(127, 127, 1024, 1024, 4096, 1024, 1024, 80, 1'b0);
    run_phase(64, 64, 512, 512, 2048, 40, 40, 80, 1'b0);
    run_phase(12, 0, 96, 40, 500, 8, 8, 30, 1'b0);
    run_phase(4, 30, 32, 240, 300, 8, 100, 100, 1'b0);
    repeat (8) begin
      run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16),
                $urandom_range(1, 16), $urandom_range(0, 1024), $urandom_range(0, 1024),
                $urandom_range(0, 4096), $urandom_range(0, 64), $urandom_range(0, 64),
                115, 1'b0);
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS heightmap_rect_placement_check");
    end else begin
      $display("FAIL heightmap_rect_placement_check");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hmrp_pkg.sv
rtl/hmrp_ram.sv
rtl/hmrp_probe.sv
rtl/heightmap_rect_placement_check.sv
bench/tb_heightmap_rect_placement_check.sv
